// File: sv/lzwvw_pkg.sv
// Shared types and constants for the LZW variable-width compressor.
// No dependencies; imported by the datapath, controller and top level.
package lzwvw_pkg;

  localparam int CODE_W     = 12;
  localparam int WIDTH_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int EPOCH_W    = 8;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE_CODE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE        = 4'd3;

  localparam logic [WIDTH_W-1:0]    RST_INITIAL_WIDTH = 4'd9;
  localparam logic [WIDTH_W-1:0]    RST_MAX_WIDTH     = 4'd12;
  localparam logic [CFG_DATA_W-1:0] RST_FIRST_FREE    = 12'd258;
  localparam logic [CFG_DATA_W-1:0] RST_END_CODE      = 12'd257;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] code_width;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic ld_in;         // latch byte, compute hash slot
    logic first_byte;    // match starts at incoming byte
    logic rd;            // read slot at probe index
    logic probe_next;    // step to next slot
    logic take_hit;      // match extends to slot's code
    logic miss;          // emit match, insert pair, restart match
    logic emit_match;    // emit pending match on finish
    logic emit_end;      // emit end code
    logic stream_start;  // reinit stream state
    logic clear_step;    // clear one slot
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_finish;
    logic match_valid;
    logic slot_hit;
    logic slot_used;
    logic out_free;
    logic clear_done;
    logic epoch_wrap;
  } ctrl_status_t;

endpackage

// File: sv/lzwvw_datapath.sv
// Datapath: config registers, match state, hashed dictionary RAM, output register.
// Depends on lzwvw_pkg; driven by lzwvw_ctrl through ctrl_cmd_t.
module lzwvw_datapath #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lzwvw_pkg::ctrl_cmd_t                cmd,
  output lzwvw_pkg::ctrl_status_t             status,
  input  lzwvw_pkg::in_item_t                 in_data,
  input  logic                                cfg_we,
  input  logic [lzwvw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lzwvw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lzwvw_pkg::out_item_t                out_data
);
  import lzwvw_pkg::*;

  localparam int CW    = MAX_CODE_BITS;
  localparam int HW    = CW + 1;
  localparam int KW    = CW + BYTE_W;
  localparam int NW    = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int DEPTH = 1 << HW;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KW-1:0]      key;
    logic [CW-1:0]      code;
  } slot_t;

  logic [WIDTH_W-1:0]    initial_width;
  logic [WIDTH_W-1:0]    max_width;
  logic [CFG_DATA_W-1:0] first_free_code;
  logic [CFG_DATA_W-1:0] end_code;

  logic [CW-1:0]      match_code;
  logic               match_valid;
  logic [NW-1:0]      next_free;
  logic [WIDTH_W-1:0] width_now;
  logic [EPOCH_W-1:0] epoch;
  logic [HW-1:0]      probe_idx;
  logic [HW-1:0]      clr_cnt;
  logic [BYTE_W-1:0]  byte_reg;
  slot_t              rdata;
  slot_t              dict_mem [DEPTH];

  logic [WIDTH_W-1:0] eff_max;
  logic [NW-1:0]      limit;
  logic [NW-1:0]      next_free_inc;
  logic               can_add;
  logic               grow;
  logic [KW-1:0]      key;
  logic [HW-1:0]      hash_idx;
  logic               out_free;

  always_comb begin
    eff_max       = ({1'b0, max_width} > 5'(CW)) ? WIDTH_W'(CW) : max_width;
    limit         = NW'(1) << eff_max;
    next_free_inc = next_free + NW'(1);
    can_add       = next_free < limit;
    grow          = (width_now < eff_max) && (next_free_inc >= (NW'(1) << width_now));
    key           = {match_code, byte_reg};
    hash_idx      = HW'({match_code, 1'b0}) ^ HW'({in_data.data_byte, {(HW-BYTE_W){1'b0}}})
                    ^ HW'(in_data.data_byte);
    out_free      = !out_valid || out_ready;
  end

  assign status.in_finish   = (in_data.cmd == CMD_FINISH);
  assign status.match_valid = match_valid;
  assign status.slot_used   = (rdata.tag == epoch);
  assign status.slot_hit    = (rdata.tag == epoch) && (rdata.key == key);
  assign status.out_free    = out_free;
  assign status.clear_done  = &clr_cnt;
  assign status.epoch_wrap  = &epoch;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_width   <= RST_INITIAL_WIDTH;
      max_width       <= RST_MAX_WIDTH;
      first_free_code <= RST_FIRST_FREE;
      end_code        <= RST_END_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_WIDTH:   initial_width   <= cfg_data[WIDTH_W-1:0];
        REG_MAX_WIDTH:       max_width       <= cfg_data[WIDTH_W-1:0];
        REG_FIRST_FREE_CODE: first_free_code <= cfg_data;
        REG_END_CODE:        end_code        <= cfg_data;
        default: ;
      endcase
    end
  end

  // match state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_code  <= '0;
      match_valid <= 1'b0;
      next_free   <= NW'(RST_FIRST_FREE);
      width_now   <= RST_INITIAL_WIDTH;
      epoch       <= EPOCH_W'(1);
      clr_cnt     <= '0;
    end else begin
      if (cmd.first_byte) begin
        match_code  <= CW'(in_data.data_byte);
        match_valid <= 1'b1;
      end
      if (cmd.take_hit)
        match_code <= rdata.code;
      if (cmd.miss) begin
        match_code <= CW'(byte_reg);
        if (can_add) begin
          next_free <= next_free_inc;
          if (grow)
            width_now <= width_now + WIDTH_W'(1);
        end
      end
      if (cmd.stream_start) begin
        match_code  <= '0;
        match_valid <= 1'b0;
        next_free   <= NW'(first_free_code);
        width_now   <= initial_width;
        // tags wrap: old entries would alias, so the RAM is swept
        if (&epoch) begin
          epoch   <= EPOCH_W'(1);
          clr_cnt <= '0;
        end else begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end
      if (cmd.clear_step)
        clr_cnt <= clr_cnt + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      byte_reg  <= in_data.data_byte;
      probe_idx <= hash_idx;
    end else if (cmd.probe_next) begin
      probe_idx <= probe_idx + HW'(1);
    end
  end

  // dictionary RAM, one port
  always_ff @(posedge clk) begin
    if (cmd.clear_step)
      dict_mem[clr_cnt] <= '0;
    else if (cmd.miss && can_add)
      dict_mem[probe_idx] <= '{tag: epoch, key: key, code: next_free[CW-1:0]};
    if (cmd.rd)
      rdata <= dict_mem[probe_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.miss || cmd.emit_match || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.miss || cmd.emit_match)
      out_data <= '{code: CODE_W'(match_code), code_width: width_now, last: 1'b0};
    else if (cmd.emit_end)
      out_data <= '{code: end_code, code_width: width_now, last: 1'b1};
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.miss || cmd.emit_match || cmd.emit_end) |-> out_free)
    else $error("word loaded over an untaken result");

  a_no_insert_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.miss |-> !status.slot_hit)
    else $error("pair inserted although already present");

  a_next_free_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.stream_start) |-> next_free >= $past(next_free))
    else $error("next free code went backwards mid-stream");

endmodule

// File: sv/lzwvw_ctrl.sv
// Controller FSM: sequences accept, hashed probe, emit, finish and RAM sweep.
// Depends on lzwvw_pkg; talks to lzwvw_datapath by ctrl_cmd_t / ctrl_status_t.
module lzwvw_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lzwvw_pkg::ctrl_status_t status,
  output lzwvw_pkg::ctrl_cmd_t    cmd
);
  import lzwvw_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR     = 6'b000001,
    ST_IDLE      = 6'b000010,
    ST_READ      = 6'b000100,
    ST_CMP       = 6'b001000,
    ST_FIN_MATCH = 6'b010000,
    ST_FIN_END   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done)
          state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.ld_in = 1'b1;
          if (status.in_finish)
            state_next = ST_FIN_MATCH;
          else if (!status.match_valid)
            cmd.first_byte = 1'b1;
          else
            state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.slot_hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_IDLE;
        end else if (status.slot_used) begin
          cmd.probe_next = 1'b1;
          state_next     = ST_READ;
        end else if (status.out_free) begin
          cmd.miss   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN_MATCH: begin
        if (!status.match_valid) begin
          state_next = ST_FIN_END;
        end else if (status.out_free) begin
          cmd.emit_match = 1'b1;
          state_next     = ST_FIN_END;
        end
      end
      ST_FIN_END: begin
        if (status.out_free) begin
          cmd.emit_end     = 1'b1;
          cmd.stream_start = 1'b1;
          state_next       = status.epoch_wrap ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_CLEAR;
    else
      state <= state_next;
  end

  a_probe_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> (state == ST_CMP))
    else $error("slot read not followed by compare");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !cmd.ld_in && !cmd.miss)
    else $error("dictionary touched during sweep");

  a_end_after_match: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_match |=> (state == ST_FIN_END))
    else $error("finish sequence broken");

endmodule

// File: sv/lzw_variable_width_compressor.sv
// LZW compressor with variable code width: top level.
// Instantiates lzwvw_ctrl and lzwvw_datapath; uses lzwvw_pkg.
//
// Input words (in_valid/in_ready) carry cmd and data_byte: cmd 0 feeds one
// byte, cmd 1 finishes the stream. Output words (out_valid/out_ready) carry
// code, code_width and last. A finish yields the pending code (if any) and
// the end code with last set. Config writes (cfg_valid/cfg_ready, always
// ready) set initial_width, max_width, first_free_code and end_code.
// A byte that opens a match is taken in the idle state; any other byte is then
// probed, once more per hash collision: each probe is a read of the single-port
// dictionary RAM and a compare. A finish steps through the emit-match and
// emit-end states. Results sit in an output register; if the receiver
// stalls, a byte that must emit waits in the compare state and no new word
// is taken until the register frees. Reset, and every 255th stream end,
// sweep the 2^(MAX_CODE_BITS+1)-entry dictionary RAM, one entry a cycle;
// no input word is taken during the sweep. Between sweeps, entries are
// retired by an epoch tag stored with each entry.
module lzw_variable_width_compressor #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lzwvw_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lzwvw_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lzwvw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzwvw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lzwvw_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  lzwvw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzwvw_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
